[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Expects signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CCG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccg assertion failed");

// Next-cycle implication, disabled while in reset
`define CCG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccg assertion failed");

`endif

[rtl/ccg_pkg.sv]
// Package for the CRC codeword generator: widths, register indexes,
// reset values and the queue entry type. No dependencies.
`default_nettype none

package ccg_pkg;

    localparam int MAX_GEN_LEN = 32;
    localparam int GEN_LEN_TOP = (MAX_GEN_LEN < 2) ? 2 :
                                 ((MAX_GEN_LEN < 32) ? MAX_GEN_LEN : 32);

    localparam int LEN_W  = 6;
    localparam int POLY_W = 31;
    localparam int REM_W  = 31;
    localparam int DEG_W  = 5;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_ADDR_W-1:0] REG_GEN_LENGTH     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GENERATOR_POLY = 1'b1;

    localparam logic [LEN_W-1:0]  GEN_LENGTH_RST     = 6'd17;
    localparam logic [POLY_W-1:0] GENERATOR_POLY_RST = 31'd4129;

    typedef struct packed {
        logic             data_bit;
        logic             quotient;
        logic             last;
        logic [REM_W-1:0] rem_aligned;
        logic [DEG_W-1:0] deg;
    } ccg_entry_t;

endpackage

`default_nettype wire

[rtl/ccg_front.sv]
// Front end: configuration registers, running remainder, and item
// classification into queue entries. Depends on ccg_pkg.
`default_nettype none

module ccg_front
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [ccg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [ccg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                              accept,
    input  wire                              data_bit,
    input  wire                              last_bit,
    output ccg_pkg::ccg_entry_t              entry
);
    import ccg_pkg::*;

    logic [LEN_W-1:0]  gen_length_reg;
    logic [POLY_W-1:0] generator_poly_reg;
    logic [REM_W-1:0]  remainder_reg;
    logic [REM_W-1:0]  remainder_next;

    logic [LEN_W-1:0]  n_eff;
    logic [DEG_W-1:0]  deg;
    logic [REM_W-1:0]  mask;
    logic [REM_W-1:0]  rem_masked;
    logic [REM_W-1:0]  rem_shift;
    logic              quo;

    always_comb
    begin
        if (gen_length_reg < LEN_W'(2))
            n_eff = LEN_W'(2);
        else if (gen_length_reg > LEN_W'(GEN_LEN_TOP))
            n_eff = LEN_W'(GEN_LEN_TOP);
        else
            n_eff = gen_length_reg;
        deg        = DEG_W'(n_eff - LEN_W'(1));
        mask       = ~({REM_W{1'b1}} << deg);
        rem_masked = remainder_reg & mask;
        quo        = data_bit ^ rem_masked[deg - DEG_W'(1)];
        rem_shift  = (rem_masked << 1) & mask;
        if (quo)
            remainder_next = rem_shift ^ (generator_poly_reg & mask);
        else
            remainder_next = rem_shift;
    end

    always_comb
    begin
        entry.data_bit    = data_bit;
        entry.quotient    = quo;
        entry.last        = last_bit;
        entry.rem_aligned = remainder_next << (DEG_W'(REM_W) - deg);
        entry.deg         = deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_length_reg     <= GEN_LENGTH_RST;
            generator_poly_reg <= GENERATOR_POLY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GEN_LENGTH:     gen_length_reg     <= cfg_wdata[LEN_W-1:0];
                REG_GENERATOR_POLY: generator_poly_reg <= cfg_wdata[POLY_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remainder_reg <= '0;
        else if (accept)
        begin
            if (last_bit)
                remainder_reg <= '0;
            else
                remainder_reg <= remainder_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ccg_queue.sv]
// Short queue of classified items between front and back ends.
// Depends on ccg_pkg.
`default_nettype none

module ccg_queue
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  ccg_pkg::ccg_entry_t  wr_data,
    output logic                 full,
    input  wire                  rd_en,
    output ccg_pkg::ccg_entry_t  rd_data,
    output logic                 empty
);
    import ccg_pkg::*;

    ccg_entry_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + Q_CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ccg_back.sv]
// Back end: output register and check-bit serializer.
// Depends on ccg_pkg.
`default_nettype none

module ccg_back
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  ccg_pkg::ccg_entry_t  q_data,
    input  wire                  q_empty,
    output logic                 q_pop,
    input  wire                  pop,
    output logic                 empty,
    output logic                 code_bit,
    output logic                 quotient_bit,
    output logic                 is_check,
    output logic                 last_out
);
    import ccg_pkg::*;

    logic              out_valid_reg;
    logic              code_reg;
    logic              quo_reg;
    logic              chk_reg;
    logic              last_reg;
    logic [REM_W-1:0]  sr_reg;
    logic [DEG_W-1:0]  cnt_reg;
    logic              advance;

    assign advance      = !out_valid_reg || pop;
    assign q_pop        = advance && (cnt_reg == '0) && !q_empty;
    assign empty        = !out_valid_reg;
    assign code_bit     = code_reg;
    assign quotient_bit = quo_reg;
    assign is_check     = chk_reg;
    assign last_out     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (advance)
        begin
            if (cnt_reg != '0)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_reg - DEG_W'(1);
            end
            else if (!q_empty)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= q_data.last ? q_data.deg : '0;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (cnt_reg != '0)
            begin
                code_reg <= sr_reg[REM_W-1];
                quo_reg  <= 1'b0;
                chk_reg  <= 1'b1;
                last_reg <= (cnt_reg == DEG_W'(1));
                sr_reg   <= sr_reg << 1;
            end
            else if (!q_empty)
            begin
                code_reg <= q_data.data_bit;
                quo_reg  <= q_data.quotient;
                chk_reg  <= 1'b0;
                last_reg <= 1'b0;
                sr_reg   <= q_data.rem_aligned;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/crc_codeword_generator_core.sv]
// Top level of the CRC codeword generator: front end, queue, back end.
// Depends on ccg_pkg, ccg_front, ccg_queue, ccg_back.
`default_nettype none

// Systematic CRC encoder. Message bits enter one per cycle while full is
// low, MSB first, and each leaves as one item carrying the bit and its
// quotient bit. An input item with last_bit set is followed at the output
// by n-1 check bits, highest first, the final one flagged last_out; the
// running remainder is cleared at once, so the next message may enter
// right away. The input takes one item per cycle unless full is high; the
// serializer emits the check bits one by one, and a 4-entry queue lets
// input run ahead meanwhile.
// n = gen_length clamped to 2..32. Write configuration only while idle.
module crc_codeword_generator_core
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [ccg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [ccg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                              push,
    output logic                             full,
    input  wire                              data_bit,
    input  wire                              last_bit,
    output logic                             empty,
    input  wire                              pop,
    output logic                             code_bit,
    output logic                             quotient_bit,
    output logic                             is_check,
    output logic                             last_out
);
    import ccg_pkg::*;

    ccg_entry_t front_entry;
    ccg_entry_t q_data;
    logic       q_empty;
    logic       q_pop;
    logic       accept;

    assign accept = push && !full;

    ccg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .data_bit  (data_bit),
        .last_bit  (last_bit),
        .entry     (front_entry)
    );

    ccg_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    ccg_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .code_bit     (code_bit),
        .quotient_bit (quotient_bit),
        .is_check     (is_check),
        .last_out     (last_out)
    );

endmodule

`default_nettype wire

[rtl/ccg_checker.sv]
// Port-level checker for crc_codeword_generator_core, bound to the top.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ccg_checker
(
    input wire clk,
    input wire rst_n,
    input wire empty,
    input wire pop,
    input wire code_bit,
    input wire quotient_bit,
    input wire is_check,
    input wire last_out
);

    `CCG_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(code_bit) && $stable(is_check))
    `CCG_ASSERT_IMP(a_chk_no_quo, !empty && is_check, !quotient_bit)
    `CCG_ASSERT_IMP(a_last_is_chk, !empty && last_out, is_check)
    `CCG_ASSERT_NXT(a_chk_run, !empty && pop && is_check && !last_out, !empty && is_check)

endmodule

bind crc_codeword_generator_core ccg_checker u_ccg_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .code_bit     (code_bit),
    .quotient_bit (quotient_bit),
    .is_check     (is_check),
    .last_out     (last_out)
);

`default_nettype wire
